>>> rtl/elliptic_cylinder_tessellation_macros.svh
// Assertion macros for the checker file of the cylinder tessellation block.
// Depends on nothing; include by bare file name.
`ifndef ELLIPTIC_CYLINDER_TESSELLATION_MACROS_SVH
`define ELLIPTIC_CYLINDER_TESSELLATION_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ECT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define ECT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after reset is seen.
`define ECT_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

>>> rtl/ect_pkg.sv
// Types, constants and helper functions for the cylinder tessellation block.
// No dependencies; the RTL modules refer to it by scoped names.
package ect_pkg;

   localparam int COORD_W     = 32;
   localparam int SUM_W       = 33;
   localparam int DIST_W      = 33;
   localparam int PROD_W      = 66;
   localparam int TRIG_W      = 32;
   localparam int TW_W        = 36;
   localparam int INDEX_W     = 9;
   localparam int AXIS_W      = 2;
   localparam int KSEL_W      = 3;
   localparam int QUOT_W      = 8;
   localparam int REQ_TDATA_W = 208;
   localparam int RSP_TDATA_W = 104;

   localparam int     CORDIC_STEPS = 30;
   localparam longint CORDIC_GAIN  = 64'sd652032874;
   localparam longint ATAN_TURN [CORDIC_STEPS] = '{
      64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756, 64'sd42667331,
      64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163, 64'sd1335087,
      64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722,
      64'sd20861, 64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304,
      64'sd652, 64'sd326, 64'sd163, 64'sd81, 64'sd41,
      64'sd20, 64'sd10, 64'sd5, 64'sd3, 64'sd1
   };

   // Half an LSB of a Q2.30 product, for round-to-nearest.
   localparam logic signed [PROD_W-1:0] Q30_HALF = PROD_W'(64'sd536870912);

   localparam logic signed [TW_W-1:0] SAT_HI = TW_W'(64'sd2147483647);
   localparam logic signed [TW_W-1:0] SAT_LO = TW_W'(-64'sd2147483648);

   typedef enum logic [AXIS_W-1:0] {
      AXIS_Z = 2'd0,
      AXIS_X = 2'd1,
      AXIS_Y = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      REGION_TOP    = 2'd0,
      REGION_SIDE   = 2'd1,
      REGION_BOTTOM = 2'd2
   } region_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_v;
      logic signed [TRIG_W-1:0] sin_v;
   } trig_type;

   // Cross products for the three ratio compares, plus zero-radius flags.
   typedef struct packed {
      logic [PROD_W-1:0] lhs_xy_yz;
      logic [PROD_W-1:0] rhs_xy_yz;
      logic [PROD_W-1:0] lhs_xy_zx;
      logic [PROD_W-1:0] rhs_xy_zx;
      logic [PROD_W-1:0] lhs_yz_zx;
      logic [PROD_W-1:0] rhs_yz_zx;
      logic              zero_xy;
      logic              zero_yz;
      logic              zero_zx;
      logic              near_round;
   } ratio_type;

   // Rotation-mode CORDIC over a 32-bit turn phase; elaboration time only.
   function automatic trig_type cordic_trig(input logic [31:0] phase);
      longint   x;
      longint   y;
      longint   z;
      longint   xs;
      longint   ys;
      trig_type res;
      x = CORDIC_GAIN;
      y = 64'sd0;
      z = longint'(phase[29:0]);
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TURN[k];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TURN[k];
         end
      end
      case (phase[31:30])
         2'd0: begin
            res.cos_v = TRIG_W'(x);
            res.sin_v = TRIG_W'(y);
         end
         2'd1: begin
            res.cos_v = TRIG_W'(-y);
            res.sin_v = TRIG_W'(x);
         end
         2'd2: begin
            res.cos_v = TRIG_W'(-x);
            res.sin_v = TRIG_W'(-y);
         end
         default: begin
            res.cos_v = TRIG_W'(y);
            res.sin_v = TRIG_W'(-x);
         end
      endcase
      return res;
   endfunction

   // Exact floor(v/3) for any 9-bit value, by reciprocal multiply.
   function automatic logic [QUOT_W-1:0] div3(input logic [INDEX_W-1:0] v);
      logic [23:0] p;
      p = 24'(v) * 24'd21846;
      return p[23:16];
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [TW_W-1:0] v);
      logic signed [COORD_W-1:0] res;
      if (v > SAT_HI) begin
         res = COORD_W'(SAT_HI);
      end else if (v < SAT_LO) begin
         res = COORD_W'(SAT_LO);
      end else begin
         res = v[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/ect_trig_table.sv
// Cosine/sine table of the ellipse points, built at elaboration by CORDIC.
// Depends on ect_pkg.
module ect_trig_table #(
   parameter int SEGMENTS = 32
) (
   input  logic [$clog2(SEGMENTS)-1:0]          entry,
   output logic signed [ect_pkg::TRIG_W-1:0]    cos_v,
   output logic signed [ect_pkg::TRIG_W-1:0]    sin_v
);

   logic signed [ect_pkg::TRIG_W-1:0] cos_tab [SEGMENTS];
   logic signed [ect_pkg::TRIG_W-1:0] sin_tab [SEGMENTS];

   for (genvar m = 0; m < SEGMENTS; m++) begin : g_entry
      // Phase in units of 2^-32 turn.
      localparam logic [63:0] PHASE = (64'(m) << 32) / 64'(SEGMENTS);
      localparam ect_pkg::trig_type TRIG = ect_pkg::cordic_trig(PHASE[31:0]);
      assign cos_tab[m] = TRIG.cos_v;
      assign sin_tab[m] = TRIG.sin_v;
   end

   assign cos_v = cos_tab[entry];
   assign sin_v = sin_tab[entry];

endmodule

>>> rtl/ect_axis_pick.sv
// Cylinder axis choice from the registered ratio cross products.
// Depends on ect_pkg.
module ect_axis_pick (
   input  ect_pkg::ratio_type ratio,
   output ect_pkg::axis_type  axis
);

   logic le_xy_yz;
   logic le_xy_zx;
   logic le_yz_zx;

   // A zero denominator is an infinite ratio; infinite <= infinite.
   always_comb begin
      if (ratio.zero_xy) begin
         le_xy_yz = ratio.zero_yz;
         le_xy_zx = ratio.zero_zx;
      end else begin
         le_xy_yz = ratio.zero_yz || (ratio.lhs_xy_yz <= ratio.rhs_xy_yz);
         le_xy_zx = ratio.zero_zx || (ratio.lhs_xy_zx <= ratio.rhs_xy_zx);
      end
      if (ratio.zero_yz) begin
         le_yz_zx = ratio.zero_zx;
      end else begin
         le_yz_zx = ratio.zero_zx || (ratio.lhs_yz_zx <= ratio.rhs_yz_zx);
      end

      if ((le_xy_yz && le_xy_zx) || ratio.near_round) begin
         axis = ect_pkg::AXIS_Z;
      end else if (le_yz_zx) begin
         axis = ect_pkg::AXIS_X;
      end else begin
         axis = ect_pkg::AXIS_Y;
      end
   end

endmodule

>>> rtl/elliptic_cylinder_tessellation.sv
// Top level of the elliptic cylinder tessellation block: six-stage vertex pipeline.
// Depends on ect_pkg, ect_trig_table and ect_axis_pick.
//
// Each request beat carries two opposite corners of an axis-aligned box and a
// mesh vertex index; each response beat carries that vertex of the triangle
// mesh of the elliptic cylinder inscribed in the box, in Q15.16 with
// saturation, plus the chosen cylinder axis. The mesh has SEGMENTS points
// around the ellipse: 3*SEGMENTS top-cap vertices, 6*SEGMENTS side vertices,
// then 3*SEGMENTS bottom-cap vertices; larger indexes wrap modulo
// 12*SEGMENTS. The block is fully pipelined: while rsp_tready is high, it
// takes one beat per cycle and returns one beat per cycle. The request is
// captured at its accepting edge and moves stage by stage to the response
// register that drives rsp_tvalid. The six register stages are input capture,
// center/radius and index decode, ratio cross products with table lookup,
// axis choice, radius-times-trig multiply, and round/saturate into the
// response register. Each stage loads whenever it is empty or its contents
// move on, so bubbles collapse and a stalled response holds only the stages
// behind it that are full. The cosine/sine table is a constant built at
// elaboration. No configuration, no state across items.
module elliptic_cylinder_tessellation #(
   parameter int SEGMENTS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
   // vertex_index, zero fill
   input  logic [ect_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_x, out_y, out_z, axis_used, zero fill
   output logic [ect_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int STAGES   = 6;
   localparam int SEG_W    = $clog2(SEGMENTS);
   localparam int MESH_N   = 12 * SEGMENTS;
   localparam int WRAP_MAX = ((1 << ect_pkg::INDEX_W) - 1) / MESH_N;
   localparam int LIM_W    = ($clog2(MESH_N + 1) > ect_pkg::INDEX_W) ?
                             $clog2(MESH_N + 1) : ect_pkg::INDEX_W;
   localparam int OFF_W    = ect_pkg::INDEX_W + 2;
   localparam logic [LIM_W-1:0] CAP_LIM  = LIM_W'(3 * SEGMENTS);
   localparam logic [LIM_W-1:0] SIDE_LIM = LIM_W'(9 * SEGMENTS);
   localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);

   localparam int CW = ect_pkg::COORD_W;
   localparam int SW = ect_pkg::SUM_W;
   localparam int DW = ect_pkg::DIST_W;
   localparam int PW = ect_pkg::PROD_W;
   localparam int TW = ect_pkg::TW_W;

   // ---------------------------------------------------------------------
   // Stage flow control: a stage loads when empty or when it drains.
   // ---------------------------------------------------------------------
   logic [STAGES+1:1] load;
   logic [STAGES:1]   en;
   logic [STAGES:1]   valid_in;
   logic [STAGES:1]   valid_ff;

   always_comb begin
      load[STAGES+1] = rsp_tready;
      for (int k = STAGES; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      en[1]       = load[1] && req_tvalid;
      valid_in[1] = load[1] ? req_tvalid : valid_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         en[k]       = load[k] && valid_ff[k-1];
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = load[1];
   assign rsp_tvalid = valid_ff[STAGES];

   // ---------------------------------------------------------------------
   // Stage 1: capture the request beat.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0]               a1_ff [3];
   logic signed [CW-1:0]               b1_ff [3];
   logic [ect_pkg::INDEX_W-1:0]        idx1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= req_tdata[i*CW +: CW];
            b1_ff[i] <= req_tdata[(i+3)*CW +: CW];
         end
         idx1_ff <= req_tdata[6*CW +: ect_pkg::INDEX_W];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: doubled center and radii, axis-pair max/min, index decode.
   // ---------------------------------------------------------------------
   logic signed [SW-1:0]               diff2;
   logic signed [SW-1:0]               sum2_in  [3];
   logic [DW-1:0]                      dist2_in [3];
   logic [DW-1:0]                      nxy2_in, dxy2_in, nyz2_in, dyz2_in, nzx2_in, dzx2_in;
   logic                               near2_in;
   logic [ect_pkg::INDEX_W-1:0]        red2;
   logic [LIM_W-1:0]                   red2_w;
   logic [ect_pkg::INDEX_W-1:0]        off2;
   logic [ect_pkg::INDEX_W-1:0]        part2;
   logic [ect_pkg::QUOT_W-1:0]         quot2;
   logic [OFF_W-1:0]                   back2;
   ect_pkg::region_type                region2_in;
   logic [SEG_W-1:0]                   seg2_in;
   logic [ect_pkg::KSEL_W-1:0]         ksel2_in;

   logic signed [SW-1:0]               sum2_ff  [3];
   logic [DW-1:0]                      dist2_ff [3];
   logic [DW-1:0]                      nxy2_ff, dxy2_ff, nyz2_ff, dyz2_ff, nzx2_ff, dzx2_ff;
   logic                               near2_ff;
   ect_pkg::region_type                region2_ff;
   logic [SEG_W-1:0]                   seg2_ff;
   logic [ect_pkg::KSEL_W-1:0]         ksel2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum2_in[i]  = SW'(a1_ff[i]) + SW'(b1_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         diff2       = SW'(a1_ff[i]) - SW'(b1_ff[i]);
         dist2_in[i] = diff2[SW-1] ? DW'(-diff2) : DW'(diff2);
      end
      nxy2_in = (dist2_in[0] > dist2_in[1]) ? dist2_in[0] : dist2_in[1];
      dxy2_in = (dist2_in[0] > dist2_in[1]) ? dist2_in[1] : dist2_in[0];
      nyz2_in = (dist2_in[1] > dist2_in[2]) ? dist2_in[1] : dist2_in[2];
      dyz2_in = (dist2_in[1] > dist2_in[2]) ? dist2_in[2] : dist2_in[1];
      nzx2_in = (dist2_in[2] > dist2_in[0]) ? dist2_in[2] : dist2_in[0];
      dzx2_in = (dist2_in[2] > dist2_in[0]) ? dist2_in[0] : dist2_in[2];
      // Near-round footprint: xy ratio at most three.
      near2_in = (dxy2_in != '0) &&
                 ((DW+2)'(nxy2_in) <= ((DW+2)'(dxy2_in) + ((DW+2)'(dxy2_in) << 1)));

      // Wrap the index into the mesh: compare against each multiple in parallel.
      red2 = idx1_ff;
      for (int k = 1; k <= WRAP_MAX; k++) begin
         if (LIM_W'(idx1_ff) >= LIM_W'(k * MESH_N)) begin
            red2 = ect_pkg::INDEX_W'(LIM_W'(idx1_ff) - LIM_W'(k * MESH_N));
         end
      end
      red2_w = LIM_W'(red2);

      if (red2_w < CAP_LIM) begin
         region2_in = ect_pkg::REGION_TOP;
         off2       = red2;
      end else if (red2_w < SIDE_LIM) begin
         region2_in = ect_pkg::REGION_SIDE;
         off2       = ect_pkg::INDEX_W'(red2_w - CAP_LIM);
      end else begin
         region2_in = ect_pkg::REGION_BOTTOM;
         off2       = ect_pkg::INDEX_W'(red2_w - SIDE_LIM);
      end

      // Caps step three vertices per segment, the side six.
      part2   = (region2_in == ect_pkg::REGION_SIDE) ? (off2 >> 1) : off2;
      quot2   = ect_pkg::div3(part2);
      back2   = (region2_in == ect_pkg::REGION_SIDE) ?
                ((OFF_W'(quot2) << 2) + (OFF_W'(quot2) << 1)) :
                ((OFF_W'(quot2) << 1) + OFF_W'(quot2));
      ksel2_in = ect_pkg::KSEL_W'(OFF_W'(off2) - back2);
      seg2_in  = quot2[SEG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sum2_ff    <= sum2_in;
         dist2_ff   <= dist2_in;
         nxy2_ff    <= nxy2_in;
         dxy2_ff    <= dxy2_in;
         nyz2_ff    <= nyz2_in;
         dyz2_ff    <= dyz2_in;
         nzx2_ff    <= nzx2_in;
         dzx2_ff    <= dzx2_in;
         near2_ff   <= near2_in;
         region2_ff <= region2_in;
         seg2_ff    <= seg2_in;
         ksel2_ff   <= ksel2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: ratio cross products, vertex role, trig table lookup.
   // ---------------------------------------------------------------------
   ect_pkg::ratio_type                 ratio3_in;
   logic                               center3_in;
   logic                               up3_in;
   logic                               pt3;
   logic [SEG_W-1:0]                   entry3;
   logic signed [ect_pkg::TRIG_W-1:0]  cos3_in;
   logic signed [ect_pkg::TRIG_W-1:0]  sin3_in;

   ect_pkg::ratio_type                 ratio3_ff;
   logic                               center3_ff;
   logic                               up3_ff;
   logic signed [ect_pkg::TRIG_W-1:0]  cos3_ff;
   logic signed [ect_pkg::TRIG_W-1:0]  sin3_ff;
   logic signed [SW-1:0]               sum3_ff  [3];
   logic [DW-1:0]                      dist3_ff [3];

   always_comb begin
      ratio3_in.lhs_xy_yz  = PW'(nxy2_ff) * PW'(dyz2_ff);
      ratio3_in.rhs_xy_yz  = PW'(nyz2_ff) * PW'(dxy2_ff);
      ratio3_in.lhs_xy_zx  = PW'(nxy2_ff) * PW'(dzx2_ff);
      ratio3_in.rhs_xy_zx  = PW'(nzx2_ff) * PW'(dxy2_ff);
      ratio3_in.lhs_yz_zx  = PW'(nyz2_ff) * PW'(dzx2_ff);
      ratio3_in.rhs_yz_zx  = PW'(nzx2_ff) * PW'(dyz2_ff);
      ratio3_in.zero_xy    = (dxy2_ff == '0);
      ratio3_in.zero_yz    = (dyz2_ff == '0);
      ratio3_in.zero_zx    = (dzx2_ff == '0);
      ratio3_in.near_round = near2_ff;

      center3_in = 1'b0;
      up3_in     = 1'b1;
      pt3        = 1'b0;
      unique case (region2_ff)
         ect_pkg::REGION_TOP: begin
            center3_in = (ksel2_ff == 3'd0);
            pt3        = (ksel2_ff == 3'd2);
            up3_in     = 1'b1;
         end
         ect_pkg::REGION_SIDE: begin
            // Two triangles per segment: (0,up)(0,dn)(1,dn) then (1,up)(0,up)(1,dn)
            case (ksel2_ff)
               3'd0:    begin pt3 = 1'b0; up3_in = 1'b1; end
               3'd1:    begin pt3 = 1'b0; up3_in = 1'b0; end
               3'd2:    begin pt3 = 1'b1; up3_in = 1'b0; end
               3'd3:    begin pt3 = 1'b1; up3_in = 1'b1; end
               3'd4:    begin pt3 = 1'b0; up3_in = 1'b1; end
               default: begin pt3 = 1'b1; up3_in = 1'b0; end
            endcase
         end
         default: begin
            center3_in = (ksel2_ff == 3'd0);
            pt3        = (ksel2_ff == 3'd1);
            up3_in     = 1'b0;
         end
      endcase

      // The last segment closes the ring on entry zero.
      if (!pt3) begin
         entry3 = seg2_ff;
      end else if (seg2_ff == SEG_LAST) begin
         entry3 = '0;
      end else begin
         entry3 = seg2_ff + SEG_W'(1);
      end
   end

   ect_trig_table #(
      .SEGMENTS (SEGMENTS)
   ) u_trig_table (
      .entry (entry3),
      .cos_v (cos3_in),
      .sin_v (sin3_in)
   );

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ratio3_ff  <= ratio3_in;
         center3_ff <= center3_in;
         up3_ff     <= up3_in;
         cos3_ff    <= cos3_in;
         sin3_ff    <= sin3_in;
         sum3_ff    <= sum2_ff;
         dist3_ff   <= dist2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: pick the axis and route the radii into the local frame.
   // ---------------------------------------------------------------------
   ect_pkg::axis_type                  axis4_in;
   logic [DW-1:0]                      du4_in, dv4_in, dw4_in;

   ect_pkg::axis_type                  axis4_ff;
   logic [DW-1:0]                      du4_ff, dv4_ff, dw4_ff;
   logic                               center4_ff;
   logic                               up4_ff;
   logic signed [ect_pkg::TRIG_W-1:0]  cos4_ff;
   logic signed [ect_pkg::TRIG_W-1:0]  sin4_ff;
   logic signed [SW-1:0]               sum4_ff [3];

   ect_axis_pick u_axis_pick (
      .ratio (ratio3_ff),
      .axis  (axis4_in)
   );

   always_comb begin
      unique case (axis4_in)
         ect_pkg::AXIS_X: begin
            du4_in = dist3_ff[1];
            dv4_in = dist3_ff[2];
            dw4_in = dist3_ff[0];
         end
         ect_pkg::AXIS_Y: begin
            du4_in = dist3_ff[2];
            dv4_in = dist3_ff[0];
            dw4_in = dist3_ff[1];
         end
         default: begin
            du4_in = dist3_ff[0];
            dv4_in = dist3_ff[1];
            dw4_in = dist3_ff[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         axis4_ff   <= axis4_in;
         du4_ff     <= du4_in;
         dv4_ff     <= dv4_in;
         dw4_ff     <= dw4_in;
         center4_ff <= center3_ff;
         up4_ff     <= up3_ff;
         cos4_ff    <= cos3_ff;
         sin4_ff    <= sin3_ff;
         sum4_ff    <= sum3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: radius times cosine/sine; cap offset along the axis.
   // ---------------------------------------------------------------------
   logic signed [PW-1:0]               pu5_in, pv5_in;
   logic signed [TW-1:0]               tw5_in;

   logic signed [PW-1:0]               pu5_ff, pv5_ff;
   logic signed [TW-1:0]               tw5_ff;
   ect_pkg::axis_type                  axis5_ff;
   logic signed [SW-1:0]               sum5_ff [3];

   always_comb begin
      if (center4_ff) begin
         pu5_in = '0;
         pv5_in = '0;
      end else begin
         pu5_in = PW'(signed'({1'b0, du4_ff})) * PW'(cos4_ff);
         pv5_in = PW'(signed'({1'b0, dv4_ff})) * PW'(sin4_ff);
      end
      tw5_in = up4_ff ? TW'(signed'({1'b0, dw4_ff})) : -TW'(signed'({1'b0, dw4_ff}));
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         pu5_ff   <= pu5_in;
         pv5_ff   <= pv5_in;
         tw5_ff   <= tw5_in;
         axis5_ff <= axis4_ff;
         sum5_ff  <= sum4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: round the products, back to x/y/z, halve, saturate.
   // ---------------------------------------------------------------------
   logic signed [PW-1:0]               ru6, rv6;
   logic signed [TW-1:0]               tu6, tv6;
   logic signed [TW-1:0]               tg6 [3];
   logic signed [TW:0]                 total6;
   logic signed [CW-1:0]               out6_in [3];

   logic signed [CW-1:0]               out6_ff [3];
   ect_pkg::axis_type                  axis6_ff;

   always_comb begin
      ru6 = pu5_ff + ect_pkg::Q30_HALF;
      rv6 = pv5_ff + ect_pkg::Q30_HALF;
      tu6 = signed'(ru6[PW-1:30]);
      tv6 = signed'(rv6[PW-1:30]);
      unique case (axis5_ff)
         ect_pkg::AXIS_X: begin
            tg6[0] = tw5_ff;
            tg6[1] = tu6;
            tg6[2] = tv6;
         end
         ect_pkg::AXIS_Y: begin
            tg6[0] = tv6;
            tg6[1] = tw5_ff;
            tg6[2] = tu6;
         end
         default: begin
            tg6[0] = tu6;
            tg6[1] = tv6;
            tg6[2] = tw5_ff;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         total6     = (TW+1)'(sum5_ff[i]) + (TW+1)'(tg6[i]);
         out6_in[i] = ect_pkg::sat_coord(signed'(total6[TW:1]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         out6_ff  <= out6_in;
         axis6_ff <= axis5_ff;
      end
   end

   assign rsp_tdata = {(ect_pkg::RSP_TDATA_W - 3*CW - ect_pkg::AXIS_W)'(0),
                       axis6_ff, out6_ff[2], out6_ff[1], out6_ff[0]};

endmodule

>>> rtl/ect_checker.sv
// Port-level checks of the cylinder tessellation block, bound to its top level.
// Depends on ect_pkg and elliptic_cylinder_tessellation_macros.svh.
`include "elliptic_cylinder_tessellation_macros.svh"

module ect_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ect_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // Hold a stalled response beat.
   `ECT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "response beat dropped while stalled")

   `ECT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata),
      "response data changed while stalled")

   // An empty response register leaves room all the way to the input.
   `ECT_ASSERT_NOW(a_empty_ready, clock, reset, !rsp_tvalid, req_tready,
      "input stalled with an empty response register")

   `ECT_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_tvalid,
      "response valid right after reset")

endmodule

bind elliptic_cylinder_tessellation ect_checker u_ect_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
